// ===== rtl/core/quadratic_root_solver_defines.svh =====
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared property shorthands for the solver's checker.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");

// Next-cycle implication, disabled during reset.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

`endif

// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, codes and shared types of the fixed-point quadratic solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int TOL_W     = 16;
    localparam int ROOT_W    = 40;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = 2 * COEF_W + 2;
    localparam int GUARD     = (61 - 2 * COEF_W) / 2;
    localparam int RAD_W     = DISC_W + 2 * GUARD;
    localparam int SQ_STEPS  = RAD_W / 2;
    localparam int SQRT_W    = SQ_STEPS;
    localparam int SQ_REM_W  = SQRT_W + 2;
    localparam int NUM_W     = SQRT_W + 2;
    localparam int DVD_W     = 2 * COEF_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register index taken from paddr[2].
    localparam logic REG_ZERO_TOL = 1'b0;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_LINEAR,
        MODE_SINGLE,
        MODE_DOUBLE
    } qrs_mode_t;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               count;
        logic signed [ROOT_W-1:0] first;
        logic signed [ROOT_W-1:0] second;
    } qrs_result_t;

endpackage

// ===== rtl/core/qrs_ifs.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver channel interfaces
// Valid/ready channels for coefficient sets and root results.
// ----------------------------------------------------------------------------
interface qrs_coef_if
    import qrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_const;

    modport source (output valid, coef_square, coef_linear, coef_const, input ready);
    modport sink (input valid, coef_square, coef_linear, coef_const, output ready);
endinterface

interface qrs_root_if
    import qrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               root_count;
    logic signed [ROOT_W-1:0] first_root;
    logic signed [ROOT_W-1:0] second_root;

    modport source (output valid, root_count, first_root, second_root, input ready);
    modport sink (input valid, root_count, first_root, second_root, output ready);
endinterface

// ===== rtl/core/qrs_datapath.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver datapath
// Pipelined discriminant, digit-by-digit square root and two restoring
// dividers; every stage advances together under one enable.
// ----------------------------------------------------------------------------
module qrs_datapath
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [COEF_W-1:0] coef_square,
    input  logic signed [COEF_W-1:0] coef_linear,
    input  logic signed [COEF_W-1:0] coef_const,
    input  logic [TOL_W-1:0]         zero_tol,
    output qrs_result_t              result
);

    typedef struct packed {
        qrs_mode_t                mode;
        logic [1:0]               count;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } sq_side_t;

    typedef struct packed {
        qrs_mode_t         mode;
        logic [1:0]        count;
        logic              neg1;
        logic              neg2;
        logic [COEF_W-1:0] dvs;
    } dv_side_t;

    function automatic logic [COEF_W-1:0] coef_mag(input logic signed [COEF_W-1:0] x);
        coef_mag = x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
    endfunction

    function automatic logic [NUM_W-1:0] num_mag(input logic signed [NUM_W-1:0] x);
        num_mag = x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
    endfunction

    // Stage A: input capture.
    logic                     a_valid_reg;
    logic signed [COEF_W-1:0] a_a_reg, a_b_reg, a_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_a_reg <= coef_square;
            a_b_reg <= coef_linear;
            a_c_reg <= coef_const;
        end
    end

    // Stage B: products and coefficient zero tests.
    logic                     b_valid_reg;
    logic signed [PROD_W-1:0] b_bb_reg, b_ac_reg;
    logic                     b_az_reg, b_bz_reg, b_cz_reg;
    logic signed [COEF_W-1:0] b_a_reg, b_b_reg, b_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_bb_reg <= a_b_reg * a_b_reg;
            b_ac_reg <= a_a_reg * a_c_reg;
            b_az_reg <= coef_mag(a_a_reg) <= zero_tol;
            b_bz_reg <= coef_mag(a_b_reg) <= zero_tol;
            b_cz_reg <= coef_mag(a_c_reg) <= zero_tol;
            b_a_reg  <= a_a_reg;
            b_b_reg  <= a_b_reg;
            b_c_reg  <= a_c_reg;
        end
    end

    // Stage C: discriminant.
    logic                     c_valid_reg;
    logic signed [DISC_W-1:0] c_d_reg;
    logic                     c_az_reg, c_bz_reg, c_cz_reg;
    logic signed [COEF_W-1:0] c_a_reg, c_b_reg, c_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_d_reg  <= DISC_W'(b_bb_reg) - {b_ac_reg, 2'b00};
            c_az_reg <= b_az_reg;
            c_bz_reg <= b_bz_reg;
            c_cz_reg <= b_cz_reg;
            c_a_reg  <= b_a_reg;
            c_b_reg  <= b_b_reg;
            c_c_reg  <= b_c_reg;
        end
    end

    // Stage D: case selection.
    logic [DISC_W-1:0] d_mag;
    logic              d_zero, d_pos;
    sq_side_t          d_side;
    logic [DISC_W-1:0] d_rad;

    always_comb
    begin
        d_mag  = c_d_reg[DISC_W-1] ? DISC_W'(-c_d_reg) : DISC_W'(c_d_reg);
        d_zero = d_mag <= DISC_W'(zero_tol);
        d_pos  = !c_d_reg[DISC_W-1] && (c_d_reg != '0);
        d_side.a = c_a_reg;
        d_side.b = c_b_reg;
        d_side.c = c_c_reg;
        if (c_az_reg)
        begin
            if (c_bz_reg)
            begin
                d_side.mode  = MODE_NONE;
                d_side.count = c_cz_reg ? CNT_INF : CNT_NONE;
            end
            else
            begin
                d_side.mode  = MODE_LINEAR;
                d_side.count = CNT_ONE;
            end
        end
        else if (d_zero)
        begin
            d_side.mode  = MODE_SINGLE;
            d_side.count = CNT_ONE;
        end
        else if (d_pos)
        begin
            d_side.mode  = MODE_DOUBLE;
            d_side.count = CNT_TWO;
        end
        else
        begin
            d_side.mode  = MODE_NONE;
            d_side.count = CNT_NONE;
        end
        d_rad = (d_side.mode == MODE_DOUBLE) ? DISC_W'(c_d_reg) : '0;
    end

    // Square root: one result bit per stage.
    logic                sq_valid_reg [0:SQ_STEPS];
    sq_side_t            sq_side_reg  [0:SQ_STEPS];
    logic [DISC_W-1:0]   sq_rad_reg   [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] sq_rem_reg   [0:SQ_STEPS];
    logic [SQRT_W-1:0]   sq_root_reg  [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= d_side;
            sq_rad_reg[0]  <= d_rad;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [RAD_W-1:0]    rad_full;
        logic [1:0]          pair;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [SQRT_W-1:0]   root_next;

        always_comb
        begin
            rad_full = {sq_rad_reg[k], {(2 * GUARD){1'b0}}};
            pair     = rad_full[2 * (SQ_STEPS - 1 - k) +: 2];
            trial    = {sq_rem_reg[k], pair} - (SQ_REM_W + 2)'({sq_root_reg[k], 2'b01});
            if (!trial[SQ_REM_W+1])
            begin
                rem_next  = trial[SQ_REM_W-1:0];
                root_next = {sq_root_reg[k][SQRT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {sq_rem_reg[k][SQ_REM_W-3:0], pair};
                root_next = {sq_root_reg[k][SQRT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
            end
        end
    end

    // Stage E1: numerators -b*2^G +/- s.
    logic                    e1_valid_reg;
    sq_side_t                e1_side_reg;
    logic signed [NUM_W-1:0] e1_n1_reg, e1_n2_reg;
    logic signed [NUM_W-1:0] e1_nb;

    assign e1_nb = -(NUM_W'(sq_side_reg[SQ_STEPS].b) <<< GUARD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg <= sq_valid_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_side_reg <= sq_side_reg[SQ_STEPS];
            e1_n1_reg   <= e1_nb + NUM_W'(sq_root_reg[SQ_STEPS]);
            e1_n2_reg   <= e1_nb - NUM_W'(sq_root_reg[SQ_STEPS]);
        end
    end

    // Stage E2: magnitudes and signs for the dividers. Each root becomes
    // |num| / |den| with both scale factors folded into the dividend.
    dv_side_t          e2_side;
    logic [DVD_W-1:0]  e2_dvd1, e2_dvd2;
    logic [COEF_W-1:0] e2_amag, e2_bmag, e2_cmag;
    logic [NUM_W-1:0]  e2_n1mag, e2_n2mag;
    logic              e2_a_neg, e2_b_pos, e2_c_pos;

    always_comb
    begin
        e2_amag  = coef_mag(e1_side_reg.a);
        e2_bmag  = coef_mag(e1_side_reg.b);
        e2_cmag  = coef_mag(e1_side_reg.c);
        e2_n1mag = num_mag(e1_n1_reg);
        e2_n2mag = num_mag(e1_n2_reg);
        e2_a_neg = e1_side_reg.a[COEF_W-1];
        e2_b_pos = !e1_side_reg.b[COEF_W-1] && (e1_side_reg.b != '0);
        e2_c_pos = !e1_side_reg.c[COEF_W-1] && (e1_side_reg.c != '0);
        e2_side.mode  = e1_side_reg.mode;
        e2_side.count = e1_side_reg.count;
        e2_side.neg1  = 1'b0;
        e2_side.neg2  = 1'b0;
        e2_side.dvs   = e2_amag;
        e2_dvd1       = '0;
        e2_dvd2       = '0;
        unique case (e1_side_reg.mode)
            MODE_LINEAR:
            begin
                e2_dvd1      = {e2_cmag, {(DVD_W - COEF_W){1'b0}}};
                e2_side.dvs  = e2_bmag;
                e2_side.neg1 = e2_c_pos ^ e1_side_reg.b[COEF_W-1];
            end
            MODE_SINGLE:
            begin
                e2_dvd1      = {1'b0, e2_bmag, {(DVD_W - COEF_W - 1){1'b0}}};
                e2_side.neg1 = e2_b_pos ^ e2_a_neg;
            end
            MODE_DOUBLE:
            begin
                e2_dvd1      = {e2_n1mag[DVD_W-2:0], 1'b0};
                e2_dvd2      = {e2_n2mag[DVD_W-2:0], 1'b0};
                e2_side.neg1 = e1_n1_reg[NUM_W-1] ^ e2_a_neg;
                e2_side.neg2 = e1_n2_reg[NUM_W-1] ^ e2_a_neg;
            end
            default:
            begin
                e2_dvd1 = '0;
            end
        endcase
    end

    // Restoring dividers: one quotient bit per stage; the quotient shifts
    // into the dividend register as the dividend shifts out.
    logic              dv_valid_reg [0:DIV_STEPS];
    dv_side_t          dv_side_reg  [0:DIV_STEPS];
    logic [DVD_W-1:0]  dv_dvd1_reg  [0:DIV_STEPS];
    logic [DVD_W-1:0]  dv_dvd2_reg  [0:DIV_STEPS];
    logic [COEF_W-1:0] dv_rem1_reg  [0:DIV_STEPS];
    logic [COEF_W-1:0] dv_rem2_reg  [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= e2_side;
            dv_dvd1_reg[0] <= e2_dvd1;
            dv_dvd2_reg[0] <= e2_dvd2;
            dv_rem1_reg[0] <= '0;
            dv_rem2_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [COEF_W:0]   cat1, cat2, dvs_ext;
        logic              ge1, ge2;
        logic [COEF_W-1:0] rem1_next, rem2_next;

        always_comb
        begin
            dvs_ext   = {1'b0, dv_side_reg[j].dvs};
            cat1      = {dv_rem1_reg[j], dv_dvd1_reg[j][DVD_W-1]};
            cat2      = {dv_rem2_reg[j], dv_dvd2_reg[j][DVD_W-1]};
            ge1       = cat1 >= dvs_ext;
            ge2       = cat2 >= dvs_ext;
            rem1_next = ge1 ? COEF_W'(cat1 - dvs_ext) : cat1[COEF_W-1:0];
            rem2_next = ge2 ? COEF_W'(cat2 - dvs_ext) : cat2[COEF_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_dvd1_reg[j+1] <= {dv_dvd1_reg[j][DVD_W-2:0], ge1};
                dv_dvd2_reg[j+1] <= {dv_dvd2_reg[j][DVD_W-2:0], ge2};
                dv_rem1_reg[j+1] <= rem1_next;
                dv_rem2_reg[j+1] <= rem2_next;
            end
        end
    end

    // Sign and masking of the finished quotients.
    logic signed [ROOT_W-1:0] q1_ext, q2_ext;
    dv_side_t                 f_side;

    always_comb
    begin
        f_side = dv_side_reg[DIV_STEPS];
        q1_ext = ROOT_W'(dv_dvd1_reg[DIV_STEPS]);
        q2_ext = ROOT_W'(dv_dvd2_reg[DIV_STEPS]);
        result.valid  = dv_valid_reg[DIV_STEPS];
        result.count  = f_side.count;
        result.first  = '0;
        result.second = '0;
        if (f_side.mode != MODE_NONE)
        begin
            result.first = f_side.neg1 ? -q1_ext : q1_ext;
        end
        if (f_side.mode == MODE_DOUBLE)
        begin
            result.second = f_side.neg2 ? -q2_ext : q2_ext;
        end
    end

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients.
// ----------------------------------------------------------------------------
// The solver accepts one coefficient set per clock while its output buffer has
// room and returns one result transaction per input, in order. The 31-stage
// digit-by-digit square root is followed by the 32-stage restoring divider;
// four stages before and two between them form the discriminant and the
// dividends. A two-entry output buffer lets the input keep flowing while a
// result waits; the whole pipeline holds only when both entries are full.
// Roots are Q24.16, truncated toward zero; zero_tolerance (address 0) sets the
// zero threshold.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    qrs_coef_if.sink           coef_in,
    qrs_root_if.source         root_out
);

    logic [TOL_W-1:0] zero_tol_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ZERO_TOL);
    assign prdata    = (paddr[2] == REG_ZERO_TOL) ? PDATA_W'(zero_tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tol_reg <= '0;
        end
        else if (cfg_write)
        begin
            zero_tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    logic        adv;
    qrs_result_t pipe_res;
    logic        out_valid_reg, skid_valid_reg;
    qrs_result_t out_data_reg, skid_data_reg;
    logic        take;

    assign adv           = !skid_valid_reg;
    assign coef_in.ready = adv;
    assign take          = out_valid_reg && root_out.ready;

    qrs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (coef_in.valid),
        .coef_square (coef_in.coef_square),
        .coef_linear (coef_in.coef_linear),
        .coef_const  (coef_in.coef_const),
        .zero_tol    (zero_tol_reg),
        .result      (pipe_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (pipe_res.valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (pipe_res.valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= pipe_res;
            end
            else
            begin
                out_data_reg <= pipe_res;
            end
        end
    end

    assign root_out.valid       = out_valid_reg;
    assign root_out.root_count  = out_data_reg.count;
    assign root_out.first_root  = out_data_reg.first;
    assign root_out.second_root = out_data_reg.second;

endmodule

// ===== rtl/core/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level properties of the solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_defines.svh"

module qrs_checker
    import qrs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               root_count,
    input logic signed [ROOT_W-1:0] first_root,
    input logic signed [ROOT_W-1:0] second_root
);

    `QRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(root_count) && $stable(first_root) && $stable(second_root))

    `QRS_ASSERT_IMP(a_no_root_zero, clk, rst_n, out_valid && (root_count == CNT_NONE || root_count == CNT_INF), first_root == '0 && second_root == '0)

    `QRS_ASSERT_IMP(a_second_only_two, clk, rst_n, out_valid && root_count != CNT_TWO, second_root == '0)

    // The input side only backs up once a result is already waiting.
    `QRS_ASSERT_IMP(a_stall_has_result, clk, rst_n, !in_ready, out_valid)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (coef_in.ready),
    .out_valid   (root_out.valid),
    .out_ready   (root_out.ready),
    .root_count  (root_out.root_count),
    .first_root  (root_out.first_root),
    .second_root (root_out.second_root)
);
